// ===== src/sha256_stream_hasher_unit_macros.svh =====
// Assertion helpers shared by the hasher modules.
`ifndef SHA256_STREAM_HASHER_UNIT_MACROS_SVH
`define SHA256_STREAM_HASHER_UNIT_MACROS_SVH

// Implication check, sampled on the rising clock, off during reset.
`define SHS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle check, sampled on the rising clock, off during reset.
`define SHS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/shs_pkg.sv =====
package shs_pkg;

  // Depth of the queue between the front and the back part.
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [0:0] {
    OP_ABSORB = 1'b0,
    OP_FINISH = 1'b1
  } op_e;

  // One classified item handed from the front to the back part.
  typedef struct packed {
    logic       finish;
    logic [7:0] data;
  } item_t;

  typedef logic [31:0] word_t;

  localparam logic [7:0] PadByte = 8'h80;

  function automatic word_t init_h(input logic [2:0] idx);
    word_t r;
    r = 32'h0;
    unique case (idx)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      3'd7: r = 32'h5be0cd19;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  function automatic word_t round_k(input logic [5:0] t);
    word_t r;
    r = 32'h0;
    unique case (t)
      6'd0: r = 32'h428a2f98;  6'd1: r = 32'h71374491;  6'd2: r = 32'hb5c0fbcf;
      6'd3: r = 32'he9b5dba5;  6'd4: r = 32'h3956c25b;  6'd5: r = 32'h59f111f1;
      6'd6: r = 32'h923f82a4;  6'd7: r = 32'hab1c5ed5;  6'd8: r = 32'hd807aa98;
      6'd9: r = 32'h12835b01;  6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
      6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
      6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
      6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
      6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
      6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
      6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
      6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
      6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
      6'd63: r = 32'hc67178f2;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/shs_front.sv =====
// Front part: accepts stream items, classifies them and queues them.
`include "sha256_stream_hasher_unit_macros.svh"

module shs_front #(
  parameter int unsigned Depth = shs_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      in_data_i,
  input  logic            in_op_i,
  output logic            q_valid_o,
  input  logic            q_ready_i,
  output shs_pkg::item_t  q_item_o
);

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  shs_pkg::item_t      mem_q [Depth];
  logic [IdxW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                push, pop;

  assign in_ready_o = (cnt_q != CntW'(Depth));
  assign q_valid_o  = (cnt_q != '0);
  assign push       = in_valid_i & in_ready_o;
  assign pop        = q_valid_o & q_ready_i;
  assign q_item_o   = mem_q[rd_q];

  // Pointer and count update with wrap at the queue depth.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == IdxW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == IdxW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Classified item storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q].finish <= (in_op_i == shs_pkg::OP_FINISH);
      mem_q[wr_q].data   <= in_data_i;
    end
  end

  `SHS_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_q <= CntW'(Depth), "queue count out of range")
  `SHS_ASSERT_NEXT(a_push_grows, push && !pop, cnt_q == $past(cnt_q) + 1'b1, "push lost")

endmodule

// ===== src/shs_back.sv =====
// Back part: fills the block, runs the rounds, pads and emits the digest.
`include "sha256_stream_hasher_unit_macros.svh"

module shs_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  output logic            q_ready_o,
  input  shs_pkg::item_t  q_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [31:0]     out_word_o,
  output logic [2:0]      out_index_o,
  output logic            out_last_o
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PAD   = 6'b000010,
    ST_ROUND = 6'b000100,
    ST_ADD   = 6'b001000,
    ST_EMIT  = 6'b010000,
    ST_LEN   = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  logic [31:0]      w_q [16];
  logic [31:0]      h_q [8];
  logic [31:0]      v_q [8];
  logic [5:0]       fill_q;
  logic [63:0]      bits_q;
  logic [5:0]       rnd_q;
  logic             fin_q;      // finish in progress
  logic             lenblk_q;   // next compression is the length block
  logic [2:0]       idx_q;
  logic             ovalid_q;

  // Byte write lane into the 16-word schedule window.
  function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] lane,
                                           input logic [7:0] b);
    logic [31:0] r;
    r = w;
    unique case (lane)
      2'd0: r[31:24] = b;
      2'd1: r[23:16] = b;
      2'd2: r[15:8]  = b;
      2'd3: r[7:0]   = b;
      default: r = w;
    endcase
    return r;
  endfunction

  // Round datapath.
  logic [31:0] wt, s0, s1, wnew, big1, ch, t1, big0, maj, t2;
  always_comb begin
    wt   = w_q[0];
    s0   = {w_q[1][6:0], w_q[1][31:7]} ^ {w_q[1][17:0], w_q[1][31:18]} ^ (w_q[1] >> 3);
    s1   = {w_q[14][16:0], w_q[14][31:17]} ^ {w_q[14][18:0], w_q[14][31:19]}
         ^ (w_q[14] >> 10);
    wnew = s1 + w_q[9] + s0 + w_q[0];
    big1 = {v_q[4][5:0], v_q[4][31:6]} ^ {v_q[4][10:0], v_q[4][31:11]}
         ^ {v_q[4][24:0], v_q[4][31:25]};
    ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1   = v_q[7] + big1 + ch + shs_pkg::round_k(rnd_q) + wt;
    big0 = {v_q[0][1:0], v_q[0][31:2]} ^ {v_q[0][12:0], v_q[0][31:13]}
         ^ {v_q[0][21:0], v_q[0][31:22]};
    maj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2   = big0 + maj;
  end

  assign q_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o = ovalid_q;
  assign out_word_o  = h_q[idx_q];
  assign out_index_o = idx_q;
  assign out_last_o  = (idx_q == 3'd7);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          // A byte or marker in the last slot fills the block.
          if (fill_q == 6'd63) begin
            state_d = ST_ROUND;
          end else if (q_item_i.finish) begin
            state_d = (fill_q == 6'd55) ? ST_LEN : ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (fill_q == 6'd63) begin
          state_d = ST_ROUND;
        end else if (fill_q == 6'd55 && lenblk_q) begin
          state_d = ST_LEN;
        end
      end
      ST_LEN:   state_d = ST_ROUND;
      ST_ROUND: if (rnd_q == 6'd63) state_d = ST_ADD;
      ST_ADD:   state_d = fin_q ? (lenblk_q ? ST_EMIT : ST_PAD) : ST_IDLE;
      ST_EMIT:  if (out_ready_i && idx_q == 3'd7) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      fill_q   <= '0;
      bits_q   <= '0;
      rnd_q    <= '0;
      fin_q    <= 1'b0;
      lenblk_q <= 1'b0;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= shs_pkg::init_h(3'(i));
      end
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            // Both the message byte and the marker byte take one slot.
            fill_q <= fill_q + 1'b1;
            if (q_item_i.finish) begin
              fin_q    <= 1'b1;
              lenblk_q <= (fill_q < 6'd56);
            end else begin
              bits_q <= bits_q + 64'd8;
            end
          end
        end
        ST_PAD: begin
          fill_q <= fill_q + 1'b1;
        end
        ST_LEN: begin
          fill_q <= '0;
        end
        ST_ROUND: begin
          rnd_q <= rnd_q + 1'b1;
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) begin
            h_q[i] <= h_q[i] + v_q[i];
          end
          lenblk_q <= 1'b1;
          ovalid_q <= fin_q & lenblk_q;
        end
        ST_EMIT: begin
          if (out_ready_i) begin
            idx_q <= idx_q + 1'b1;
            if (idx_q == 3'd7) begin
              ovalid_q <= 1'b0;
              fin_q    <= 1'b0;
              lenblk_q <= 1'b0;
              fill_q   <= '0;
              bits_q   <= '0;
              for (int i = 0; i < 8; i++) begin
                h_q[i] <= shs_pkg::init_h(3'(i));
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Schedule window and working variables.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          w_q[fill_q[5:2]] <= put_byte(w_q[fill_q[5:2]], fill_q[1:0],
                                       q_item_i.finish ? shs_pkg::PadByte : q_item_i.data);
        end
      end
      ST_PAD: begin
        // After the marker byte only zeros follow until the length field.
        w_q[fill_q[5:2]] <= put_byte(w_q[fill_q[5:2]], fill_q[1:0], 8'h00);
      end
      ST_LEN: begin
        w_q[14] <= bits_q[63:32];
        w_q[15] <= bits_q[31:0];
      end
      ST_ROUND: begin
        for (int i = 0; i < 15; i++) begin
          w_q[i] <= w_q[i+1];
        end
        w_q[15] <= wnew;
        v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4]; v_q[4] <= v_q[3] + t1;
        v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0]; v_q[0] <= t1 + t2;
      end
      default: ;
    endcase
    if (state_d == ST_ROUND && state_q != ST_ROUND) begin
      for (int i = 0; i < 8; i++) begin
        v_q[i] <= h_q[i];
      end
    end
  end

  `SHS_ASSERT_IMPL(a_emit_valid, state_q == ST_EMIT, ovalid_q, "emit without valid")
  `SHS_ASSERT_IMPL(a_busy_blocks, state_q != ST_IDLE, !q_ready_o, "accepts while busy")
  `SHS_ASSERT_NEXT(a_round_step, state_q == ST_ROUND && rnd_q != 6'd63,
                   state_q == ST_ROUND, "round sequence broken")

endmodule

// ===== src/sha256_stream_hasher_unit.sv =====
// SHA-256 stream hasher.
// Input channel s_axis: one transfer per item. tuser is the operation (0 absorb
// a byte, 1 finish); tdata holds the message byte, ignored on finish.
// Output channel m_axis: eight transfers per finish, digest words first word
// first; tuser carries the word index and tlast marks the eighth word.
// An absorb writes its byte in the back part; every 64th byte starts a
// compression of the block followed by the hash update, during which the back
// part takes no new byte. A finish writes the marker, pads byte by byte up to
// the length field (and adds a second block when fewer than nine bytes are
// free), compresses, then offers the digest words one per cycle while the
// receiver is ready.
// A two-entry queue in front lets the sender run ahead of the back part.
// Reset loads the initial hash values, clears the byte count and bit length.
// When the receiver stalls, the current word holds and the back part waits;
// the queue keeps accepting until it is full. After the last word the state
// returns to its reset values for the next message.
module sha256_stream_hasher_unit #(
  parameter int unsigned QueueDepth = shs_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser,   // [2:0] word_index
  output logic        m_axis_tlast    // last
);

  logic           q_valid, q_ready;
  shs_pkg::item_t q_item;

  shs_front #(.Depth(QueueDepth)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_data_i(s_axis_tdata), .in_op_i(s_axis_tuser),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  shs_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_item_i(q_item),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_word_o(m_axis_tdata), .out_index_o(m_axis_tuser), .out_last_o(m_axis_tlast)
  );

endmodule

// ===== tb/sha256_digest_checker.sv =====
module sha256_digest_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic [2:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  logic [31:0] chain_h [8];
  logic [7:0]  msg_block [64];
  logic [5:0]  byte_fill;
  logic [63:0] bit_length;
  digest_word_t digest_q[$];
  int fails;

  localparam logic [31:0] HStart [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
  localparam logic [31:0] KTab [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  assign fail_count_o = fails;
  assign pending_o = digest_q.size();

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Run the 64 rounds over the block held and fold them into the chain.
  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    for (int t = 16; t < 64; t++)
      w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
           + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
    {a, b, c, d, e, f, g, h} = {chain_h[0], chain_h[1], chain_h[2], chain_h[3],
                                chain_h[4], chain_h[5], chain_h[6], chain_h[7]};
    for (int t = 0; t < 64; t++) begin
      t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) + KTab[t] + w[t];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
    chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
  endtask

  // Pad, append the bit length, and queue the eight digest words.
  task automatic finish_message();
    int i;
    i = byte_fill;
    msg_block[i++] = shs_pkg::PadByte;
    if (i > 56) begin
      while (i < 64) msg_block[i++] = 8'h00;
      compress_block();
      i = 0;
    end
    while (i < 56) msg_block[i++] = 8'h00;
    for (int k = 0; k < 8; k++) msg_block[63-k] = bit_length[8*k +: 8];
    compress_block();
    for (int k = 0; k < 8; k++) digest_q.push_back('{chain_h[k], 3'(k), k == 7});
    chain_h = HStart;
    byte_fill = '0;
    bit_length = '0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_h = HStart;
      byte_fill = '0;
      bit_length = '0;
      fails = 0;
      digest_q.delete();
    end else begin
      // Output side first: a transfer must match the oldest expected word.
      if (m_axis_tvalid && m_axis_tready) begin
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest word %h", $time, m_axis_tdata);
          fails++;
        end else begin
          digest_word_t exp_w;
          exp_w = digest_q.pop_front();
          if (exp_w.word !== m_axis_tdata || exp_w.index !== m_axis_tuser
              || exp_w.last !== m_axis_tlast) begin
            $display("%0t: expected word %h index %0d last %b, got %h index %0d last %b",
                     $time, exp_w.word, exp_w.index, exp_w.last,
                     m_axis_tdata, m_axis_tuser, m_axis_tlast);
            fails++;
          end
        end
      end
      // Input side: absorb a byte or close the message.
      if (s_axis_tvalid && s_axis_tready) begin
        if (shs_pkg::op_e'(s_axis_tuser) == shs_pkg::OP_ABSORB) begin
          msg_block[byte_fill] = s_axis_tdata;
          bit_length += 64'd8;
          byte_fill++;
          if (byte_fill == 0) compress_block();
        end else begin
          finish_message();
        end
      end
    end
  end
endmodule

// ===== tb/tb_top.sv =====
module tb_top;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = shs_pkg::OP_ABSORB;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  int          fail_count;
  int          pending;
  bit          sink_on = 1'b0;
  int          stall_left = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  sha256_stream_hasher_unit DUT (.*);

  sha256_digest_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .fail_count_o(fail_count), .pending_o(pending));

  // Mostly short gaps, now and then a long one, and stretches of none.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one item and hold it until a transfer takes it. The valid line
  // only drops when a gap follows, so back-to-back items keep it high.
  task automatic send_item(input shs_pkg::op_e op, input logic [7:0] data);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_message(input int n_bytes);
    for (int i = 0; i < n_bytes; i++) send_item(shs_pkg::OP_ABSORB, 8'($urandom));
    send_item(shs_pkg::OP_FINISH, 8'($urandom));
  endtask

  // Receiver with random stalls of random length.
  always @(posedge clk_i) begin
    if (sink_on) begin
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left    <= stall_left - 1;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left    <= gap_len();
      end
    end
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int n_sent;
    int len;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    sink_on = 1'b1;
    @(posedge clk_i);

    // Directed: empty message, byte extremes, finish with a nonzero data byte.
    send_item(shs_pkg::OP_FINISH, 8'hff);
    send_item(shs_pkg::OP_ABSORB, 8'h00);
    send_item(shs_pkg::OP_FINISH, 8'h00);
    send_item(shs_pkg::OP_ABSORB, 8'hff);
    send_item(shs_pkg::OP_ABSORB, 8'h80);
    send_item(shs_pkg::OP_ABSORB, 8'h7f);
    send_item(shs_pkg::OP_FINISH, 8'h5a);
    send_item(shs_pkg::OP_FINISH, 8'h00);

    // Random messages; lengths around the padding and block boundaries.
    n_sent = 0;
    while (n_sent < 450) begin
      case ($urandom_range(0, 5))
        0: len = $urandom_range(0, 8);
        1: len = $urandom_range(54, 57);
        2: len = $urandom_range(62, 66);
        3: len = $urandom_range(118, 130);
        default: len = $urandom_range(0, 40);
      endcase
      send_message(len);
      n_sent += len + 1;
    end
    s_axis_tvalid <= 1'b0;

    // Let the checker record the last transfer, drain, then let the block settle.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
